// ===== hw/rtl/ggf_pkg.sv =====
// Shared types and constants for the grid gap filler.
// Holds the neighbor table, field widths and the back-end state encoding.
package ggf_pkg;

  localparam int LEN_W    = 11;  // line_length register and cell counters
  localparam int CNT_W    = 16;  // line_count register and line counters
  localparam int LINE_W   = 17;  // input line counter, runs a few lines past the frame
  localparam int LAG_W    = 13;  // 2 * line_length + 2
  localparam int VAL_W    = 8;
  localparam int NB_COUNT = 21;  // center plus twenty neighbors
  localparam int NB_W     = 5;
  localparam int WT_W     = 6;
  localparam int NUM_W    = 18;
  localparam int DEN_W    = 9;
  localparam int QUO_W    = 8;
  localparam int QDEPTH   = 2;
  localparam int DATA_W   = 16;  // configuration write data

  localparam logic signed [VAL_W-1:0] EMPTY_CELL = -8'sd1;

  localparam logic REG_LINE_LENGTH = 1'b0;
  localparam logic REG_LINE_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GATHER,
    B_PREP,
    B_DIVIDE,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [2:0] dl;
    logic signed [2:0] dc;
    logic [WT_W-1:0]   wt;
  } nb_t;

  // Entry 0 is the center cell; the others carry weight 40 / squared distance.
  function automatic nb_t nb_entry(input logic [NB_W-1:0] k);
    nb_t e;
    case (k)
      5'd0:    e = '{dl:  3'sd0, dc:  3'sd0, wt: 6'd0};
      5'd1:    e = '{dl: -3'sd2, dc: -3'sd2, wt: 6'd5};
      5'd2:    e = '{dl: -3'sd2, dc:  3'sd0, wt: 6'd10};
      5'd3:    e = '{dl: -3'sd2, dc:  3'sd2, wt: 6'd5};
      5'd4:    e = '{dl: -3'sd1, dc: -3'sd2, wt: 6'd8};
      5'd5:    e = '{dl: -3'sd1, dc: -3'sd1, wt: 6'd20};
      5'd6:    e = '{dl: -3'sd1, dc:  3'sd0, wt: 6'd40};
      5'd7:    e = '{dl: -3'sd1, dc:  3'sd1, wt: 6'd20};
      5'd8:    e = '{dl: -3'sd1, dc:  3'sd2, wt: 6'd8};
      5'd9:    e = '{dl:  3'sd0, dc: -3'sd2, wt: 6'd10};
      5'd10:   e = '{dl:  3'sd0, dc: -3'sd1, wt: 6'd40};
      5'd11:   e = '{dl:  3'sd0, dc:  3'sd1, wt: 6'd40};
      5'd12:   e = '{dl:  3'sd0, dc:  3'sd2, wt: 6'd10};
      5'd13:   e = '{dl:  3'sd1, dc: -3'sd2, wt: 6'd8};
      5'd14:   e = '{dl:  3'sd1, dc: -3'sd1, wt: 6'd20};
      5'd15:   e = '{dl:  3'sd1, dc:  3'sd0, wt: 6'd40};
      5'd16:   e = '{dl:  3'sd1, dc:  3'sd1, wt: 6'd20};
      5'd17:   e = '{dl:  3'sd1, dc:  3'sd2, wt: 6'd8};
      5'd18:   e = '{dl:  3'sd2, dc: -3'sd2, wt: 6'd5};
      5'd19:   e = '{dl:  3'sd2, dc:  3'sd0, wt: 6'd10};
      5'd20:   e = '{dl:  3'sd2, dc:  3'sd2, wt: 6'd5};
      default: e = '{dl:  3'sd0, dc:  3'sd0, wt: 6'd0};
    endcase
    return e;
  endfunction

endpackage

// ===== hw/rtl/grid_gap_fill_idw_top.sv =====
// Grid gap filler top level: configuration registers, front end, job
// queue and back end. Uses ggf_pkg, ggf_front, ggf_queue and ggf_back.
//
// Cells of a raster grid enter on the s_ channel one beat per cell, line
// after line; tuser marks a padding beat. Filled cells leave unchanged, an
// empty cell (-1) leaves as the inverse-squared-distance weighted mean of
// its filled neighbors, with m_tuser high when it was interpolated and
// m_tlast on the last cell of the frame. Results trail the input by two
// lines plus two cells; further beats after the frame, padding or not, flush them out.
// Writes on wr_en set line_length (index 0) or line_count (index 1) and
// restart the frame.
// Each result gathers 21 line-store reads through the single read port;
// an empty cell that is filled in from its neighbors then adds an 8-step
// quotient. The front end runs ahead by up to two queued jobs plus the
// two-line lead-in, so input flows freely until the queue fills.
// Reset clears all counters, the queue and the result register; the line
// store needs no clearing. While m_tready is low the result beat holds,
// the back end stops and the front end stalls once the queue is full.
module grid_gap_fill_idw_top import ggf_pkg::*; #(
  parameter int MAX_LINE = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // cell_value
  input  logic              s_tuser,   // is_padding
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // filled_value
  output logic              m_tuser,   // was_filled
  output logic              m_tlast,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int AW    = $clog2(8 * MAX_LINE + 16);
  localparam int JW    = AW + CNT_W + LEN_W + 1;
  localparam int CLAMP = (MAX_LINE > 2047) ? 2047 : MAX_LINE;

  logic [LEN_W-1:0] line_length;
  logic [CNT_W-1:0] line_count;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] cnt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             job_push;
  logic [JW-1:0]    job_in;
  logic             job_full;
  logic             job_pop;
  logic             job_valid;
  logic [JW-1:0]    job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_W'(1024);
      line_count  <= CNT_W'(1024);
    end else if (wr_en) begin
      case (wr_index)
        REG_LINE_LENGTH: line_length <= wr_data[LEN_W-1:0];
        REG_LINE_COUNT:  line_count  <= wr_data;
        default: ;
      endcase
    end
  end

  assign len = (line_length == '0) ? LEN_W'(1)
             : ((32'(line_length) > MAX_LINE) ? LEN_W'(CLAMP) : line_length);
  assign cnt = (line_count == '0) ? CNT_W'(1) : line_count;

  ggf_front #(.AW(AW), .JW(JW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .len       (len),
    .cnt       (cnt),
    .restart   (wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job_push  (job_push),
    .job_data  (job_in),
    .job_full  (job_full)
  );

  ggf_queue #(.JW(JW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_data  (job_in),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_data  (job_out)
  );

  ggf_back #(.AW(AW), .JW(JW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .len       (len),
    .cnt       (cnt),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job_valid (job_valid),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== hw/rtl/ggf_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Uses ggf_pkg for the depth.
module ggf_queue import ggf_pkg::*; #(
  parameter int JW = 42
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [JW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output logic [JW-1:0] head_data
);

  logic [JW-1:0] slots [QDEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full       = (fill == 2'(QDEPTH));
  assign head_valid = (fill != 2'd0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== hw/rtl/ggf_front.sv =====
// Front end: accepts cells, writes them to the line store and queues one
// job per result position. Uses ggf_pkg for widths and constants.
module ggf_front import ggf_pkg::*; #(
  parameter int AW = 14,
  parameter int JW = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] len,
  input  logic [CNT_W-1:0] cnt,
  input  logic             restart,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tuser,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [VAL_W-1:0] mem_wdata,
  output logic             job_push,
  output logic [JW-1:0]    job_data,
  input  logic             job_full
);

  typedef struct packed {
    logic [AW-1:0]    addr;
    logic [CNT_W-1:0] line;
    logic [LEN_W-1:0] col;
    logic             last;
  } job_t;

  logic [AW-1:0]     ptr;
  logic [LINE_W-1:0] in_line;
  logic [LEN_W-1:0]  in_cell;
  logic [LAG_W-1:0]  pre;
  logic [CNT_W-1:0]  out_line;
  logic [LEN_W-1:0]  out_cell;

  logic [LAG_W-1:0]  lag;
  logic              accept;
  logic              emit;
  logic              out_last;
  job_t              job;

  assign lag      = LAG_W'({len, 1'b0}) + LAG_W'(2);
  assign s_tready = !job_full;
  assign accept   = s_tvalid && !job_full;
  assign emit     = (pre == lag);
  assign out_last = (out_line == cnt - CNT_W'(1)) && (out_cell == len - LEN_W'(1));
  assign job_push = accept && emit;

  always_comb begin
    job.addr = ptr - AW'(lag);
    job.line = out_line;
    job.col  = out_cell;
    job.last = out_last;
  end
  assign job_data = job;

  // cells past the end of the frame are flush items and are not stored
  assign mem_we    = accept && (in_line < LINE_W'(cnt));
  assign mem_waddr = ptr;
  assign mem_wdata = s_tuser ? EMPTY_CELL : s_tdata;

  // ptr keeps running across frames so queued jobs of the old frame stay valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      in_line  <= '0;
      in_cell  <= '0;
      pre      <= '0;
      out_line <= '0;
      out_cell <= '0;
    end else if (restart) begin
      in_line  <= '0;
      in_cell  <= '0;
      pre      <= '0;
      out_line <= '0;
      out_cell <= '0;
    end else if (accept) begin
      ptr <= ptr + AW'(1);
      if (emit && out_last) begin
        in_line  <= '0;
        in_cell  <= '0;
        pre      <= '0;
        out_line <= '0;
        out_cell <= '0;
      end else begin
        if (in_cell == len - LEN_W'(1)) begin
          in_cell <= '0;
          in_line <= in_line + LINE_W'(1);
        end else begin
          in_cell <= in_cell + LEN_W'(1);
        end
        if (!emit) pre <= pre + LAG_W'(1);
        if (emit) begin
          if (out_cell == len - LEN_W'(1)) begin
            out_cell <= '0;
            out_line <= out_line + CNT_W'(1);
          end else begin
            out_cell <= out_cell + LEN_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ggf_back.sv =====
// Back end: holds the line store, gathers the neighbors of each queued
// position, divides and drives the result beat. Uses ggf_pkg.
module ggf_back import ggf_pkg::*; #(
  parameter int AW = 14,
  parameter int JW = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] len,
  input  logic [CNT_W-1:0] cnt,
  input  logic             mem_we,
  input  logic [AW-1:0]    mem_waddr,
  input  logic [VAL_W-1:0] mem_wdata,
  input  logic             job_valid,
  input  logic [JW-1:0]    job_data,
  output logic             job_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  typedef struct packed {
    logic [AW-1:0]    addr;
    logic [CNT_W-1:0] line;
    logic [LEN_W-1:0] col;
    logic             last;
  } job_t;

  back_state_t state, state_next;

  logic [VAL_W-1:0] mem [2**AW];
  logic signed [VAL_W-1:0] rd_data;

  job_t                    job_q;
  logic [NB_W-1:0]         k;
  logic                    rd_live;
  logic                    rd_ok;
  logic                    rd_center;
  logic [WT_W-1:0]         rd_wt;
  logic signed [VAL_W-1:0] center;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic [9:0]              rem;
  logic [QUO_W-1:0]        dvd;
  logic [QUO_W-1:0]        quo;
  logic [2:0]              step;
  logic                    neg;
  logic                    pass;
  logic                    use_div;

  logic                    issue;
  logic                    out_free;
  logic                    out_load;
  nb_t                     nb;
  logic signed [17:0]      nl;
  logic signed [12:0]      nc;
  logic                    in_grid;
  logic [AW-1:0]           off_l;
  logic [AW-1:0]           raddr;
  logic signed [14:0]      prod;
  logic [NUM_W-1:0]        mag;
  logic [9:0]              trial;
  logic                    ge;
  logic [QUO_W:0]          qsign;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (job_valid) state_next = B_GATHER;
      B_GATHER: if (k == NB_W'(NB_COUNT)) state_next = B_PREP;
      B_PREP:   state_next = (center != EMPTY_CELL || den == '0) ? B_EMIT : B_DIVIDE;
      B_DIVIDE: if (step == 3'(QUO_W - 1)) state_next = B_EMIT;
      B_EMIT:   if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    job_pop  = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      B_IDLE:   job_pop  = job_valid;
      B_GATHER: issue    = (k != NB_W'(NB_COUNT));
      B_EMIT:   out_load = out_free;
      default: ;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // neighbor geometry
  always_comb begin
    nb      = nb_entry(k);
    nl      = $signed({2'b00, job_q.line}) + 18'(nb.dl);
    nc      = $signed({2'b00, job_q.col}) + 13'(nb.dc);
    in_grid = !nl[17] && (nl < $signed({2'b00, cnt}))
           && !nc[12] && (nc < $signed({2'b00, len}));
    case (nb.dl)
      -3'sd2, 3'sd2: off_l = AW'(len) << 1;
      -3'sd1, 3'sd1: off_l = AW'(len);
      default:       off_l = '0;
    endcase
    raddr = job_q.addr + (nb.dl[2] ? (~off_l + AW'(1)) : off_l) + AW'(nb.dc);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[raddr];
  end

  assign prod  = $signed({1'b0, rd_wt}) * rd_data;
  assign mag   = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign trial = {rem[8:0], dvd[QUO_W-1]};
  assign ge    = (trial >= 10'(den));
  assign qsign = neg ? (~{1'b0, quo} + (QUO_W+1)'(1)) : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      rd_live <= 1'b0;
      step    <= '0;
    end else begin
      rd_live <= issue;
      if (job_pop) k <= '0;
      else if (issue) k <= k + NB_W'(1);
      if (state == B_PREP) step <= '0;
      else if (state == B_DIVIDE) step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_q <= job_data;
      num   <= '0;
      den   <= '0;
    end
    rd_ok     <= in_grid;
    rd_center <= (k == '0);
    rd_wt     <= nb.wt;
    if (rd_live) begin
      if (rd_center) begin
        center <= rd_data;
      end else if (rd_ok && rd_data != EMPTY_CELL) begin
        num <= num + NUM_W'(prod);
        den <= den + DEN_W'(rd_wt);
      end
    end
    if (state == B_PREP) begin
      pass    <= (center != EMPTY_CELL);
      use_div <= (den != '0);
      neg     <= num[NUM_W-1];
      rem     <= {1'b0, mag[16:8]};
      dvd     <= mag[7:0];
      quo     <= '0;
    end
    if (state == B_DIVIDE) begin
      rem <= ge ? (trial - 10'(den)) : trial;
      quo <= {quo[QUO_W-2:0], ge};
      dvd <= {dvd[QUO_W-2:0], 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= pass ? center : (use_div ? qsign[QUO_W-1:0] : EMPTY_CELL);
      m_tuser <= !pass && use_div;
      m_tlast <= job_q.last;
    end
  end

endmodule

// ===== hw/rtl/ggf_checker.sv =====
// Port-level checks for the grid gap filler, bound to the top level.
// Depends on ggf_pkg for the configuration data width.
module ggf_checker import ggf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [7:0]        s_tdata,
  input logic              s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [7:0]        m_tdata,
  input logic              m_tuser,
  input logic              m_tlast,
  input logic              wr_en,
  input logic              wr_index,
  input logic [DATA_W-1:0] wr_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
      && $stable(m_tuser) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // reset drops any pending result
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // reset empties the job queue, so input is taken at once
  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

endmodule

bind grid_gap_fill_idw_top ggf_checker u_ggf_checker (.*);

// ===== tb/sv/tb_grid_gap_fill_idw_top.sv =====
// Self-checking bench for grid_gap_fill_idw_top: streams raster frames in,
// predicts every filled cell and compares it beat by beat. Needs ggf_pkg.
module tb_grid_gap_fill_idw_top import ggf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN    = 1024;
  localparam int RING       = 4 * MAX_LEN + 5;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_LEN   = 800;

  typedef struct {
    logic [7:0] cval;
    logic       pad;
    logic       drain;  // pause here until nothing is outstanding
  } cell_beat_t;

  typedef struct {
    logic [7:0] value;
    logic       filled;
    logic       last;
  } fill_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;   // cell_value
  logic s_tuser = 1'b0;       // is_padding
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;        // filled_value
  logic m_tuser;              // was_filled
  logic m_tlast;
  logic wr_en = 1'b0;
  logic wr_index = REG_LINE_LENGTH;
  logic [DATA_W-1:0] wr_data = '0;

  grid_gap_fill_idw_top dut (.*);

  initial forever #2 clk = ~clk;

  // grid model state
  logic signed [7:0] grid_ring [RING];
  logic [10:0] len_reg = 11'd1024;
  logic [15:0] cnt_reg = 16'd1024;
  int unsigned in_line, in_cell, out_line, out_cell;

  cell_beat_t cell_q[$];
  fill_out_t  fill_q[$];

  int tx_idle = 0;
  int rx_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;
  int cells_in = 0;
  int fills_out = 0;
  int interp_out = 0;
  int frames_done = 0;
  int quiet = 0;

  function automatic int idw_weight(int adl, int adc);
    case ({adl[1:0], adc[1:0]})
      4'b0001, 4'b0100: return 40;
      4'b0101:          return 20;
      4'b0010, 4'b1000: return 10;
      4'b0110:          return 8;
      4'b1010:          return 5;
      default:          return 0;
    endcase
  endfunction

  task automatic restart_frame();
    in_line = 0; in_cell = 0; out_line = 0; out_cell = 0;
  endtask

  task automatic predict_fill(input logic [7:0] cval, input logic pad);
    int unsigned len, cnt, total, lag, pos;
    int center, result, num, den, w, v, nl, nc, adl, adc;
    fill_out_t e;
    len = (len_reg == 0) ? 1 : (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
    cnt = (cnt_reg == 0) ? 1 : cnt_reg;
    total = len * cnt;
    lag = 2 * len + 2;
    pos = in_line * len + in_cell;
    num = 0; den = 0;
    if (pos < total) grid_ring[pos % RING] = pad ? EMPTY_CELL : $signed(cval);
    in_cell++;
    if (in_cell >= len) begin
      in_cell = 0;
      in_line++;
    end
    if (pos < lag) return;
    center = grid_ring[(out_line * len + out_cell) % RING];
    result = center;
    e.filled = 1'b0;
    if (center == -1) begin
      for (int dl = -2; dl <= 2; dl++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          adl = dl < 0 ? -dl : dl;
          adc = dc < 0 ? -dc : dc;
          w = idw_weight(adl, adc);
          nl = int'(out_line) + dl;
          nc = int'(out_cell) + dc;
          if (w == 0 || nl < 0 || nl >= int'(cnt) || nc < 0 || nc >= int'(len)) continue;
          v = grid_ring[(nl * len + nc) % RING];
          if (v == -1) continue;
          num += w * v;
          den += w;
        end
      end
      if (den != 0) begin
        result = num / den;
        e.filled = 1'b1;
      end
    end
    e.value = result[7:0];
    e.last = (out_line == cnt - 1 && out_cell == len - 1);
    fill_q.insert(fill_q.size(), e);
    out_cell++;
    if (out_cell >= len) begin
      out_cell = 0;
      out_line++;
    end
    if (e.last) restart_frame();
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, fills_out);
    err_count++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) predict_fill(s_tdata, s_tuser);
      if (cell_q.size() > 0 && cell_q[0].drain && fill_q.size() == 0 && !s_tvalid)
        void'(cell_q.pop_front());
      if (cell_q.size() > 0 && !cell_q[0].drain && $urandom_range(99) >= tx_idle) begin
        s_tdata <= cell_q[0].cval;
        s_tuser <= cell_q[0].pad;
        s_tvalid <= 1'b1;
        void'(cell_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    fill_out_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall);
      if (m_tvalid && m_tready) begin
        fills_out++;
        if (fill_q.size() == 0) begin
          report("unexpected beat", $signed(m_tdata), 0);
        end else begin
          e = fill_q.pop_front();
          if (m_tdata !== e.value) report("filled_value", $signed(m_tdata), $signed(e.value));
          if (m_tuser !== e.filled) report("was_filled", m_tuser, e.filled);
          if (m_tlast !== e.last) report("frame_last", m_tlast, e.last);
          if (e.filled) interp_out++;
          if (e.last) frames_done++;
        end
      end
    end
  end

  // watchdog on beats and writes
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("Timeout: no beat for %0d cycles", QUIET_MAX);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_cell(input logic [7:0] cval, input logic pad);
    cell_beat_t b;
    b.cval = cval;
    b.pad = pad;
    b.drain = 1'b0;
    cell_q.insert(cell_q.size(), b);
    cells_in++;
  endtask

  task automatic push_drain();
    cell_beat_t b;
    b.cval = 8'h00;
    b.pad = 1'b0;
    b.drain = 1'b1;
    cell_q.insert(cell_q.size(), b);
  endtask

  function automatic logic [7:0] rand_cell();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'hFF;
    if (r < 90) return 8'($urandom_range(100));
    return 8'($urandom);
  endfunction

  // wait out all traffic, then write one register and restart the frame
  task automatic set_reg(input logic idx, input int val);
    while (cell_q.size() > 0 || s_tvalid || fill_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= DATA_W'(val);
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_LINE_LENGTH) len_reg = 11'(val);
    else cnt_reg = 16'(val);
    restart_frame();
  endtask

  // one frame of random cells, optionally cut short, then the flush beats unless cut
  task automatic push_frame(input int len, input int cnt, input bit cut);
    int n;
    n = cut ? $urandom_range(len * cnt) : len * cnt;
    for (int i = 0; i < n; i++) push_cell(rand_cell(), $urandom_range(15) == 0);
    if (!cut) for (int i = 0; i < 2 * len + 2; i++) push_cell(8'($urandom), 1'($urandom));
  endtask

  initial begin
    int len, cnt, p;
    restart_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame with extremes, a padded cell and non-padding flush beats
    set_reg(REG_LINE_LENGTH, 3);
    set_reg(REG_LINE_COUNT, 3);
    push_cell(8'd100, 1'b0); push_cell(8'hFF, 1'b0); push_cell(8'd0, 1'b0);
    push_cell(8'hFF, 1'b0);  push_cell(8'hFF, 1'b0); push_cell(8'd100, 1'b1);
    push_cell(8'h80, 1'b0);  push_cell(8'hFF, 1'b0); push_cell(8'h7F, 1'b0);
    for (int i = 0; i < 8; i++) push_cell(8'hA5, 1'b0);

    // zero registers act as one: a lone empty cell stays empty
    set_reg(REG_LINE_LENGTH, 0);
    set_reg(REG_LINE_COUNT, 0);
    push_cell(8'hFF, 1'b0);
    for (int i = 0; i < 3; i++) push_cell(8'h5A, 1'b1);
    push_cell(8'd42, 1'b0);
    for (int i = 0; i < 3; i++) push_cell(8'h00, 1'b0);

    // longest line count, single-cell lines, partial frame
    set_reg(REG_LINE_LENGTH, 1);
    set_reg(REG_LINE_COUNT, 65535);
    for (int i = 0; i < 30; i++) push_cell(rand_cell(), 1'b0);

    p = 0;
    while (cells_in < 1650) begin
      case (p % 4)
        0: begin tx_idle = 0;  rx_stall = 0;  end
        1: begin tx_idle = 71; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 71; end
        default: begin tx_idle = 26; rx_stall = 26; end
      endcase
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 9);
      cnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      if (p == 2) begin
        len = 9; cnt = 5; tx_idle = 0; rx_stall = 0;
      end
      set_reg(REG_LINE_LENGTH, len);
      set_reg(REG_LINE_COUNT, cnt);
      if (len == 0) len = 1;
      if (cnt == 0) cnt = 1;
      if (p == 2) hold_req++;
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        push_frame(len, cnt, $urandom_range(4) == 0 && f == 1);
        if (p == 3) push_drain();
      end
      p++;
    end

    while (cell_q.size() > 0 || s_tvalid || fill_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d input beats over %0d random geometries, %0d frames closed,",
             cells_in, p, frames_done);
    $display("%0d results checked, %0d of them interpolated", fills_out, interp_out);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
